[design/getr_pkg.sv]
// Package for the grid energy term reduction unit.
// Holds widths, fixed-point types, register codes and the saturating helpers.
// No dependencies.
`default_nettype none

package getr_pkg;

  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int DATA_FRAC  = 24;
  localparam int ACC_FRAC   = 32;
  localparam int PROD_SHIFT = 2 * DATA_FRAC - ACC_FRAC;
  localparam int OPA_W      = DATA_W + 1;
  localparam int HDN_W      = DATA_W + 2;
  localparam int PROD_W     = HDN_W + DATA_W;
  localparam int TERM_W     = PROD_W - PROD_SHIFT;
  localparam int NSUM       = 5;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int SUM_NA      = 0;
  localparam int SUM_FIELD   = 1;
  localparam int SUM_HARTREE = 2;
  localparam int SUM_XC_UP   = 3;
  localparam int SUM_XC_DOWN = 4;

  localparam int MODE_NA    = 0;
  localparam int MODE_FIELD = 1;
  localparam int MODE_CORR  = 2;
  localparam int MODE_SPIN  = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OPA_W-1:0]  opa_t;
  typedef logic signed [HDN_W-1:0]  hdn_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef acc_t [NSUM-1:0]          sum_vec_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_INIT_NA      = 3'd1,
    REG_INIT_FIELD   = 3'd2,
    REG_INIT_HARTREE = 3'd3,
    REG_INIT_XC_UP   = 3'd4,
    REG_INIT_XC_DOWN = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    sum_vec_t          init;
  } cfg_t;

  typedef struct packed {
    logic [NSUM-1:0] hit;
  } sum_load_t;

  typedef struct packed {
    logic en_na;
    logic en_field;
    logic en_corr;
    logic en_down;
    logic last;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    opa_t  tden;
    hdn_t  hden;
    opa_t  xc_up_den;
    opa_t  xc_dn_den;
    opa_t  ref_up_den;
    opa_t  ref_dn_den;
    data_t ref_pot;
    data_t na_pot;
    data_t field_pot;
    data_t hartree_pot;
    data_t xc_up_pot;
    data_t xc_dn_pot;
  } point_t;

  // Arithmetic shift into Q18.32; rounds toward minus infinity.
  function automatic term_t scale_term(prod_t p);
    prod_t s;
    s = p >>> PROD_SHIFT;
    scale_term = s[TERM_W-1:0];
  endfunction

  function automatic acc_t sat_add(acc_t acc, term_t term);
    logic signed [ACC_W:0] wide;
    wide = {acc[ACC_W-1], acc} + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sat_add = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = wide[ACC_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[design/getr_ifs.sv]
// Channel interfaces of the grid energy term reduction unit: point input,
// energy result and configuration write. Depends on getr_pkg.
`default_nettype none

interface getr_in_if;
  import getr_pkg::*;
  logic  valid;
  logic  ready;
  data_t spin_up_density;
  data_t spin_down_density;
  data_t atomic_density;
  data_t core_density_up;
  data_t core_density_down;
  data_t reference_xc_potential;
  data_t neutral_atom_potential;
  data_t external_field_potential;
  data_t hartree_potential_change;
  data_t xc_potential_up;
  data_t xc_potential_down;
  logic  is_last;

  modport source (
    output valid, spin_up_density, spin_down_density, atomic_density,
           core_density_up, core_density_down, reference_xc_potential,
           neutral_atom_potential, external_field_potential,
           hartree_potential_change, xc_potential_up, xc_potential_down, is_last,
    input  ready
  );
  modport sink (
    input  valid, spin_up_density, spin_down_density, atomic_density,
           core_density_up, core_density_down, reference_xc_potential,
           neutral_atom_potential, external_field_potential,
           hartree_potential_change, xc_potential_up, xc_potential_down, is_last,
    output ready
  );
endinterface

interface getr_out_if;
  import getr_pkg::*;
  logic valid;
  logic ready;
  acc_t na_energy;
  acc_t field_energy;
  acc_t hartree_energy;
  acc_t xc_energy_up;
  acc_t xc_energy_down;

  modport source (
    output valid, na_energy, field_energy, hartree_energy, xc_energy_up, xc_energy_down,
    input  ready
  );
  modport sink (
    input  valid, na_energy, field_energy, hartree_energy, xc_energy_up, xc_energy_down,
    output ready
  );
endinterface

interface getr_cfg_if;
  import getr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ACC_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/grid_energy_term_reduction_unit.sv]
// Top level of the grid energy term reduction unit.
// Depends on getr_pkg, the getr interfaces, getr_cfg, getr_front, getr_queue and getr_back.
//
//   channel   direction  handshake     request contents
//   in_ch     in         valid/ready   one grid point: eleven Q8.24 values and is_last
//   out_ch    out        valid/ready   five Q32.32 energy sums, one per pass
//   cfg_ch    in         valid/ready   register index and 64-bit write data
//
// One grid point is accepted per clock while the queue is not full; the combinational accumulator adders set that rate.
// A pass result passes the queue, the product and term stages, then the result register.
// A four-entry queue lets the front keep accepting while a finished result waits;
// the pipe stalls only when a pass ends with the result register still full.
// Reset is synchronous and clears the configuration registers, the queue pointers, the sums and all valid bits.
// cfg_ch is always ready; an initial value write also reloads its sum.
`default_nettype none

module grid_energy_term_reduction_unit (
  input  wire         clk,
  input  wire         rst_n,
  getr_in_if.sink     in_ch,
  getr_out_if.source  out_ch,
  getr_cfg_if.sink    cfg_ch
);
  import getr_pkg::*;

  cfg_t      cfg;
  sum_load_t load;
  point_t    point;
  point_t    q_data;
  logic      push, q_full, q_valid, q_pop;

  getr_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg),
    .load   (load)
  );

  getr_front u_front (
    .in_ch  (in_ch),
    .mode   (cfg.mode),
    .q_full (q_full),
    .push   (push),
    .point  (point)
  );

  getr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (point),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  getr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .load    (load),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[design/getr_cfg.sv]
// Configuration registers: mode flags and the five initial sum values.
// Depends on getr_pkg and getr_cfg_if.
`default_nettype none

module getr_cfg (
  input  wire                   clk,
  input  wire                   rst_n,
  getr_cfg_if.sink              cfg_ch,
  output getr_pkg::cfg_t        cfg,
  output getr_pkg::sum_load_t   load
);
  import getr_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  sum_vec_t          init_r, init_nxt;
  sum_load_t         load_r, load_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    init_nxt = init_r;
    load_nxt = '0;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MODE: begin
          mode_nxt = cfg_ch.data[MODE_W-1:0];
        end
        REG_INIT_NA: begin
          init_nxt[SUM_NA] = cfg_ch.data;
          load_nxt.hit[SUM_NA] = 1'b1;
        end
        REG_INIT_FIELD: begin
          init_nxt[SUM_FIELD] = cfg_ch.data;
          load_nxt.hit[SUM_FIELD] = 1'b1;
        end
        REG_INIT_HARTREE: begin
          init_nxt[SUM_HARTREE] = cfg_ch.data;
          load_nxt.hit[SUM_HARTREE] = 1'b1;
        end
        REG_INIT_XC_UP: begin
          init_nxt[SUM_XC_UP] = cfg_ch.data;
          load_nxt.hit[SUM_XC_UP] = 1'b1;
        end
        REG_INIT_XC_DOWN: begin
          init_nxt[SUM_XC_DOWN] = cfg_ch.data;
          load_nxt.hit[SUM_XC_DOWN] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      init_r <= '0;
      load_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      init_r <= init_nxt;
      load_r <= load_nxt;
    end
  end

  // The load strobe is registered together with the initial register, so the
  // sum copies the initial register while it already holds the new value.
  assign load     = load_r;
  assign cfg.mode = mode_r;
  assign cfg.init = init_r;

endmodule

`default_nettype wire

[design/getr_front.sv]
// Front end: takes a grid point request, forms the exact operand sums and
// tags it with the enabled terms. Depends on getr_pkg and getr_in_if.
`default_nettype none

module getr_front (
  getr_in_if.sink               in_ch,
  input  wire [3:0]             mode,
  input  wire                   q_full,
  output logic                  push,
  output getr_pkg::point_t      point
);
  import getr_pkg::*;

  opa_t tden;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign tden = opa_t'(in_ch.spin_up_density) + opa_t'(in_ch.spin_down_density);

  always_comb begin
    point.ctl.en_na    = mode[MODE_NA];
    point.ctl.en_field = mode[MODE_FIELD];
    point.ctl.en_corr  = mode[MODE_CORR];
    point.ctl.en_down  = mode[MODE_SPIN];
    point.ctl.last     = in_ch.is_last;
    point.tden         = tden;
    point.hden         = hdn_t'(tden) - (hdn_t'(in_ch.atomic_density) <<< 1);
    point.xc_up_den    = opa_t'(in_ch.spin_up_density) + opa_t'(in_ch.core_density_up);
    point.xc_dn_den    = opa_t'(in_ch.spin_down_density) + opa_t'(in_ch.core_density_down);
    point.ref_up_den   = opa_t'(in_ch.atomic_density) + opa_t'(in_ch.core_density_up);
    point.ref_dn_den   = opa_t'(in_ch.atomic_density) + opa_t'(in_ch.core_density_down);
    point.ref_pot      = in_ch.reference_xc_potential;
    point.na_pot       = in_ch.neutral_atom_potential;
    point.field_pot    = in_ch.external_field_potential;
    point.hartree_pot  = in_ch.hartree_potential_change;
    point.xc_up_pot    = in_ch.xc_potential_up;
    point.xc_dn_pot    = in_ch.xc_potential_down;
  end

endmodule

`default_nettype wire

[design/getr_queue.sv]
// Short register queue between the front end and the accumulator back end.
// Depends on getr_pkg.
`default_nettype none

module getr_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  getr_pkg::point_t      push_data,
  input  wire                   pop,
  output logic                  q_valid,
  output getr_pkg::point_t      q_data,
  output logic                  q_full
);
  import getr_pkg::*;

  point_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/getr_back.sv]
// Back end: product stage, scaling stage, five saturating accumulators and
// the result register. Depends on getr_pkg and getr_out_if.
`default_nettype none

module getr_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  input  getr_pkg::point_t      q_data,
  output logic                  q_pop,
  input  getr_pkg::cfg_t        cfg,
  input  getr_pkg::sum_load_t   load,
  getr_out_if.source            out_ch
);
  import getr_pkg::*;

  // Product stage.
  logic  s1_vld_r;
  ctl_t  s1_ctl_r;
  prod_t p_na_r, p_field_r, p_hartree_r, p_xu_r, p_cu_r, p_xd_r, p_cd_r;
  prod_t p_na_nxt, p_field_nxt, p_hartree_nxt, p_xu_nxt, p_cu_nxt, p_xd_nxt, p_cd_nxt;

  // Scaled term stage.
  logic  s2_vld_r;
  ctl_t  s2_ctl_r;
  term_t t_na_r, t_field_r, t_hartree_r, t_xu_r, t_xd_r;
  term_t t_na_nxt, t_field_nxt, t_hartree_nxt, t_xu_nxt, t_xd_nxt;
  prod_t xu_diff, xd_diff;

  sum_vec_t sums_r, sums_nxt, upd;
  sum_vec_t res_r, res_nxt;
  logic     out_vld_r, out_vld_nxt;
  logic     stall, adv, emit;

  // Only a pass end that meets an occupied result register that is not being taken holds the pipe.
  assign stall = s2_vld_r && s2_ctl_r.last && out_vld_r && !out_ch.ready;
  assign adv   = !stall;
  assign q_pop = q_valid && adv;
  assign emit  = adv && s2_vld_r && s2_ctl_r.last;

  always_comb begin
    p_na_nxt      = q_data.tden * q_data.na_pot;
    p_field_nxt   = q_data.tden * q_data.field_pot;
    p_hartree_nxt = q_data.hden * q_data.hartree_pot;
    p_xu_nxt      = q_data.xc_up_den * q_data.xc_up_pot;
    p_cu_nxt      = q_data.ref_up_den * q_data.ref_pot;
    p_xd_nxt      = q_data.xc_dn_den * q_data.xc_dn_pot;
    p_cd_nxt      = q_data.ref_dn_den * q_data.ref_pot;
  end

  always_comb begin
    xu_diff       = s1_ctl_r.en_corr ? p_xu_r - p_cu_r : p_xu_r;
    xd_diff       = s1_ctl_r.en_corr ? p_xd_r - p_cd_r : p_xd_r;
    t_na_nxt      = scale_term(p_na_r);
    t_field_nxt   = scale_term(p_field_r);
    t_hartree_nxt = scale_term(p_hartree_r);
    t_xu_nxt      = scale_term(xu_diff);
    t_xd_nxt      = scale_term(xd_diff);
  end

  always_comb begin
    upd = sums_r;
    if (s2_ctl_r.en_na) begin
      upd[SUM_NA] = sat_add(sums_r[SUM_NA], t_na_r);
    end
    if (s2_ctl_r.en_field) begin
      upd[SUM_FIELD] = sat_add(sums_r[SUM_FIELD], t_field_r);
    end
    upd[SUM_HARTREE] = sat_add(sums_r[SUM_HARTREE], t_hartree_r);
    upd[SUM_XC_UP]   = sat_add(sums_r[SUM_XC_UP], t_xu_r);
    if (s2_ctl_r.en_down) begin
      upd[SUM_XC_DOWN] = sat_add(sums_r[SUM_XC_DOWN], t_xd_r);
    end

    sums_nxt    = sums_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (adv && s2_vld_r) begin
      sums_nxt = upd;
    end
    if (emit) begin
      res_nxt     = upd;
      out_vld_nxt = 1'b1;
      sums_nxt    = cfg.init;
    end
    for (int k = 0; k < NSUM; k++) begin
      if (load.hit[k]) begin
        sums_nxt[k] = cfg.init[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sums_r    <= '0;
    end else begin
      if (adv) begin
        s1_vld_r <= q_valid;
        s2_vld_r <= s1_vld_r;
      end
      out_vld_r <= out_vld_nxt;
      sums_r    <= sums_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r    <= q_data.ctl;
      p_na_r      <= p_na_nxt;
      p_field_r   <= p_field_nxt;
      p_hartree_r <= p_hartree_nxt;
      p_xu_r      <= p_xu_nxt;
      p_cu_r      <= p_cu_nxt;
      p_xd_r      <= p_xd_nxt;
      p_cd_r      <= p_cd_nxt;
      s2_ctl_r    <= s1_ctl_r;
      t_na_r      <= t_na_nxt;
      t_field_r   <= t_field_nxt;
      t_hartree_r <= t_hartree_nxt;
      t_xu_r      <= t_xu_nxt;
      t_xd_r      <= t_xd_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.na_energy      = res_r[SUM_NA];
  assign out_ch.field_energy   = res_r[SUM_FIELD];
  assign out_ch.hartree_energy = res_r[SUM_HARTREE];
  assign out_ch.xc_energy_up   = res_r[SUM_XC_UP];
  assign out_ch.xc_energy_down = res_r[SUM_XC_DOWN];

endmodule

`default_nettype wire

[design/getr_checker.sv]
// Port-level checks for the grid energy term reduction unit, bound to the top level.
// Depends on getr_pkg.
`default_nettype none

module getr_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input getr_pkg::acc_t out_na_energy,
  input getr_pkg::acc_t out_field_energy,
  input getr_pkg::acc_t out_hartree_energy,
  input getr_pkg::acc_t out_xc_energy_up,
  input getr_pkg::acc_t out_xc_energy_down
);
  import getr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_na_energy) && $stable(out_field_energy) &&
      $stable(out_hartree_energy) && $stable(out_xc_energy_up) &&
      $stable(out_xc_energy_down))
    else $error("result payload changed while stalled");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind grid_energy_term_reduction_unit getr_checker u_getr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_na_energy      (out_ch.na_energy),
  .out_field_energy   (out_ch.field_energy),
  .out_hartree_energy (out_ch.hartree_energy),
  .out_xc_energy_up   (out_ch.xc_energy_up),
  .out_xc_energy_down (out_ch.xc_energy_down)
);

`default_nettype wire
